// File: src/arpc_pkg.sv
// Shared types, constants and helper functions for the ARP cache unit.
package arpc_pkg;

  localparam int unsigned IP_W       = 32;
  localparam int unsigned MAC_W      = 48;
  localparam int unsigned AGE_W      = 8;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned EXP_W      = 6;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned IN_DATA_W  = IP_W + MAC_W;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USED_W = 1 + MAC_W + SLOT_W + 1 + EXP_W;
  localparam int unsigned LFSR_W     = 16;
  localparam int unsigned MOD_STEPS  = 3;
  localparam int unsigned MSTEP_W    = 2;

  localparam logic [LFSR_W-1:0] LFSR_SEED   = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_MASK   = 16'hB400;
  localparam logic [AGE_W-1:0]  TIMEOUT_RST = 8'd15;
  localparam logic [AGE_W-1:0]  AGE_MAX     = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef struct packed {
    logic load;
    logic match;
    logic pick;
    logic mod_start;
    logic mod_step;
    logic cnt_step;
    logic commit;
  } arpc_cmd_t;

  typedef struct packed {
    op_e  op;
    logic match_any;
    logic free_any;
    logic mod_last;
    logic cnt_last;
  } arpc_stat_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] r;
    r = v >> 1;
    if (v[0]) begin
      r = r ^ LFSR_MASK;
    end
    return r;
  endfunction

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r = r + {3'b000, v[i]};
    end
    return r;
  endfunction

endpackage

// File: src/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arpc_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/arpc_ctrl.sv
// Controller state machine: sequences compare, pick, modulo, count and commit.
module arpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  input  arpc_pkg::arpc_stat_t stat_i,
  output arpc_pkg::arpc_cmd_t  cmd_o
);
  import arpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_PICK,
    S_MOD,
    S_CNT,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || m_tready_i;
  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = s_tvalid_i;
        if (s_tvalid_i) begin
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = (stat_i.op == OP_TICK) ? S_CNT : S_PICK;
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        if (stat_i.op == OP_INSERT && !stat_i.match_any && !stat_i.free_any) begin
          cmd_o.mod_start = 1'b1;
          state_d         = S_MOD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) begin
          state_d = S_DONE;
        end
      end
      S_CNT: begin
        cmd_o.cnt_step = 1'b1;
        if (stat_i.cnt_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_accept_to_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (state_q == S_MATCH))
    else $error("accepted item did not start compare");

  a_mod_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> (stat_i.op == OP_INSERT))
    else $error("replacement pick outside insert");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (out_valid_q && state_q == S_IDLE))
    else $error("commit did not present a result");

endmodule

// File: src/arpc_dp.sv
// Datapath: entry table, parallel compare, aging, replacement pick and result register.
module arpc_dp #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [arpc_pkg::AGE_W-1:0]      cfg_wdata_i,
  input  logic [arpc_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic [arpc_pkg::OP_W-1:0]       s_tuser_i,
  input  arpc_pkg::arpc_cmd_t             cmd_i,
  output arpc_pkg::arpc_stat_t            stat_o,
  output logic [arpc_pkg::OUT_DATA_W-1:0] m_tdata_o
);
  import arpc_pkg::*;

  localparam int unsigned SW   = $clog2(ENTRIES);
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned NGRP = (ENTRIES + 7) / 8;
  localparam int unsigned GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam logic [31:0]       RECIP = 32'((64'd1 << 32) / 64'(ENTRIES));
  localparam logic [LFSR_W-1:0] ENT_L = LFSR_W'(ENTRIES);

  function automatic logic [SW-1:0] first_set(input logic [ENTRIES-1:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (v[k]) begin
        r = SW'(k);
      end
    end
    return r;
  endfunction

  op_e                 op_q;
  logic [IP_W-1:0]     op_ip_q;
  logic [MAC_W-1:0]    op_mac_q;
  logic [AGE_W-1:0]    timeout_q;
  logic [LFSR_W-1:0]   lfsr_q;
  logic [ENTRIES-1:0]  valid_q;
  logic [AGE_W-1:0]    age_q [ENTRIES];
  logic [IP_W-1:0]     ip_q  [ENTRIES];
  logic [ENTRIES-1:0]  match_q, free_q;
  logic [NGRP*8-1:0]   exp_q;
  logic [GW-1:0]       grp_q;
  logic [CW-1:0]       count_q;
  logic                hit_q, repl_q;
  logic [SW-1:0]       idx_q;
  logic [LFSR_W-1:0]   sh_q;
  logic [LFSR_W-1:0]   quo_q;
  logic [LFSR_W-1:0]   diff_q;
  logic [SW-1:0]       rem_q;
  logic [MSTEP_W-1:0]  mstep_q;
  logic [OUT_DATA_W-1:0] out_q;

  logic [AGE_W-1:0]    age_inc [ENTRIES];
  logic [ENTRIES-1:0]  exp_now, match_now;
  logic [LFSR_W+31:0]  recip_prod;
  logic [LFSR_W-1:0]   quo_ent;
  logic [SW-1:0]       sel_idx, rd_idx;
  logic                tick_apply, ins_commit;
  logic [MAC_W-1:0]    ram_rdata;
  logic                r_hit, r_repl;
  logic [MAC_W-1:0]    r_mac;
  logic [SW-1:0]       r_slot;
  logic [CW-1:0]       r_cnt;
  logic [SW+SLOT_W-1:0] slot_ext;
  logic [CW+EXP_W-1:0]  cnt_ext;

  assign tick_apply = cmd_i.match && (op_q == OP_TICK);
  assign ins_commit = cmd_i.commit && (op_q == OP_INSERT);
  assign sel_idx    = repl_q ? rem_q : idx_q;
  assign rd_idx     = first_set(match_q);
  assign recip_prod = (LFSR_W + 32)'(sh_q) * (LFSR_W + 32)'(RECIP);
  assign quo_ent    = quo_q * ENT_L;

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      age_inc[k]   = (age_q[k] == AGE_MAX) ? AGE_MAX : age_q[k] + 1'b1;
      exp_now[k]   = valid_q[k] && (age_inc[k] >= timeout_q);
      match_now[k] = valid_q[k] && (ip_q[k] == op_ip_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      lfsr_q    <= LFSR_SEED;
      op_q      <= OP_NOP;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (cmd_i.mod_start) begin
        lfsr_q <= lfsr_next(lfsr_q);
      end
      if (cmd_i.load) begin
        op_q <= op_e'(s_tuser_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int k = 0; k < ENTRIES; k++) begin
        age_q[k] <= '0;
      end
    end else if (tick_apply) begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (valid_q[k]) begin
          age_q[k] <= age_inc[k];
        end
        if (exp_now[k]) begin
          valid_q[k] <= 1'b0;
        end
      end
    end else if (ins_commit) begin
      age_q[sel_idx] <= '0;
      if (!hit_q) begin
        valid_q[sel_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_ip_q  <= s_tdata_i[IP_W-1:0];
      op_mac_q <= s_tdata_i[IN_DATA_W-1:IP_W];
    end
    if (ins_commit && !hit_q) begin
      ip_q[sel_idx] <= op_ip_q;
    end
    if (cmd_i.match) begin
      match_q <= match_now;
      free_q  <= ~valid_q;
      grp_q   <= '0;
      count_q <= '0;
    end
    if (tick_apply) begin
      exp_q <= (NGRP * 8)'(exp_now);
    end
    if (cmd_i.cnt_step) begin
      count_q <= count_q + CW'(popcnt8(exp_q[{grp_q, 3'b000} +: 8]));
      grp_q   <= grp_q + 1'b1;
    end
    if (cmd_i.pick) begin
      hit_q  <= |match_q;
      idx_q  <= (|match_q) ? rd_idx : first_set(free_q);
      repl_q <= cmd_i.mod_start;
    end
    if (cmd_i.mod_start) begin
      sh_q    <= lfsr_next(lfsr_q);
      mstep_q <= '0;
    end else if (cmd_i.mod_step) begin
      quo_q   <= recip_prod[LFSR_W+31:32];
      diff_q  <= sh_q - quo_ent;
      rem_q   <= (diff_q >= ENT_L) ? SW'(diff_q - ENT_L) : diff_q[SW-1:0];
      mstep_q <= mstep_q + 1'b1;
    end
    if (cmd_i.commit) begin
      out_q <= OUT_DATA_W'({cnt_ext[EXP_W-1:0], r_repl, slot_ext[SLOT_W-1:0], r_mac, r_hit});
    end
  end

  arpc_ram #(
    .WIDTH (MAC_W),
    .DEPTH (ENTRIES)
  ) u_mac_ram (
    .clk_i   (clk_i),
    .we_i    (ins_commit && !hit_q),
    .waddr_i (sel_idx),
    .wdata_i (op_mac_q),
    .re_i    (cmd_i.pick),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    r_hit  = 1'b0;
    r_mac  = '0;
    r_slot = '0;
    r_repl = 1'b0;
    r_cnt  = '0;
    case (op_q)
      OP_LOOKUP: begin
        r_hit = hit_q;
        if (hit_q) begin
          r_mac  = ram_rdata;
          r_slot = idx_q;
        end
      end
      OP_INSERT: begin
        r_hit  = hit_q;
        r_slot = sel_idx;
        r_repl = repl_q;
      end
      OP_TICK: begin
        r_cnt = count_q;
      end
      default: begin
        r_hit = 1'b0;
      end
    endcase
  end

  assign slot_ext = {{SLOT_W{1'b0}}, r_slot};
  assign cnt_ext  = {{EXP_W{1'b0}}, r_cnt};

  assign stat_o.op        = op_q;
  assign stat_o.match_any = |match_q;
  assign stat_o.free_any  = |free_q;
  assign stat_o.mod_last  = (mstep_q == MSTEP_W'(MOD_STEPS - 1));
  assign stat_o.cnt_last  = (grp_q == GW'(NGRP - 1));
  assign m_tdata_o        = out_q;

endmodule

// File: src/arp_cache_table_with_aging_unit.sv
// ARP cache top level: fully associative IPv4-to-MAC table with aging.
// Lookup and insert: compare, then pick, then a registered result; a new item is taken only after commit.
// Replacing a valid entry on insert adds an LFSR modulo (reciprocal multiply, subtract, correct).
// Tick: ages all entries, then counts the expired ones, 8 entries a cycle.
// Reset clears valid bits and ages, seeds the LFSR with 0xACE1, timeout to 15.
module arp_cache_table_with_aging_unit #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [arpc_pkg::AGE_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [arpc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // ip_addr, mac_addr
  input  logic [arpc_pkg::OP_W-1:0]       s_axis_tuser_i,  // cmd
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [arpc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o   // hit, mac_out, slot,
                                                           // replaced, expired_count
);
  import arpc_pkg::*;

  arpc_cmd_t  cmd;
  arpc_stat_t stat;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  arpc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .m_tdata_o   (m_axis_tdata_o)
  );

endmodule
